/* design/rpq_pkg.sv */
// rpq_pkg: shared types, sizes and the ordering function of the request
// priority queue.
// No dependencies.
package rpq_pkg;

    localparam int CAPACITY    = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KID_W       = IDX_W + 2;
    localparam int ID_W        = 8;
    localparam int TIME_W      = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic MODE_ARRIVAL  = 1'b0;
    localparam logic MODE_DEADLINE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   requester_id;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] deadline_time;
    } req_t;

    typedef struct packed {
        logic                   head_valid;
        logic [ID_W-1:0]        head_id;
        logic [COUNT_OUT_W-1:0] waiting_count;
        logic                   push_dropped;
        logic                   remove_missed;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] deadline;
    } entry_t;

    typedef struct packed {
        logic wr_sel;
        logic in_use;
    } cell_ctl_t;

    // true when a is served no later than b
    function automatic logic comes_first(entry_t a, entry_t b, logic mode);
        logic r;
        if (mode == MODE_DEADLINE && a.deadline != b.deadline)
        begin
            r = (a.deadline < b.deadline);
        end
        else if (a.arrival != b.arrival)
        begin
            r = (a.arrival < b.arrival);
        end
        else
        begin
            r = (a.id <= b.id);
        end
        return r;
    endfunction

endpackage

/* design/rpq_cell.sv */
// rpq_cell: one heap slot; holds an entry, matches its id against the
// remove key and passes the first-match chain to the next slot.
// Depends on rpq_pkg.
module rpq_cell
    import rpq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    wr_data,
    input  logic [ID_W-1:0] key,
    input  logic      seen_in,
    output logic      seen_out,
    output logic      hit,
    output entry_t    q
);

    entry_t slot_reg;
    logic   match;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_sel)
        begin
            slot_reg <= wr_data;
        end
    end

    assign match    = ctl.in_use && (slot_reg.id == key);
    assign hit      = match && !seen_in;
    assign seen_out = seen_in || match;
    assign q        = slot_reg;

endmodule

/* design/request_priority_queue.sv */
// request_priority_queue: binary min-heap of waiting requests over a row of
// slot cells, with a sequencer for sift-up and sift-down.
// Depends on rpq_pkg and rpq_cell.
// One slot read port: a sift-up step reads the parent (S_UP_RD), then compares
// and writes (S_UP_CMP); a sift-down level reads the left child (S_DN_L),
// compares it (S_DN_LC), then compares the right child if any (S_DN_RC).
// One item at a time; busy drops while the done strobe is shown.
// Reset clears the count and order mode; slot contents stay unknown.
module request_priority_queue
    import rpq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_UP_RD,
        S_UP_CMP,
        S_DN_START,
        S_DN_L,
        S_DN_LC,
        S_DN_RC,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  orig_reg, orig_next;
    entry_t            m_reg, m_next;
    entry_t            rd_reg, rd_next;
    entry_t            best_reg, best_next;
    logic              took_reg, took_next;
    logic              removing_reg, removing_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic              dropped_reg, dropped_next;
    logic              missed_reg, missed_next;
    logic              mode_reg, mode_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    entry_t            cell_q [CAPACITY];
    logic [CAPACITY:0] seen;
    logic [CAPACITY-1:0] hit_vec;
    logic [IDX_W-1:0]  hit_idx;
    logic              found;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_bus;

    logic [KID_W-1:0]  kid_l, kid_r, cnt_ext;
    logic [IDX_W-1:0]  up_idx;
    logic [CNT_W-1:0]  cnt_dec;
    entry_t            new_entry;

    assign seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        cell_ctl_t ctl;
        assign ctl.wr_sel = wr_en && (wr_addr == IDX_W'(g));
        assign ctl.in_use = (CNT_W'(g) < cnt_reg);

        rpq_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .wr_data  (wr_data),
            .key      (key_reg),
            .seen_in  (seen[g]),
            .seen_out (seen[g+1]),
            .hit      (hit_vec[g]),
            .q        (cell_q[g])
        );
    end

    assign found = seen[CAPACITY];

    always_comb
    begin
        hit_idx = '0;
        rd_bus  = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (hit_vec[k])
            begin
                hit_idx = hit_idx | IDX_W'(k);
            end
            if (rd_addr == IDX_W'(k))
            begin
                rd_bus = cell_q[k];
            end
        end
    end

    assign kid_l   = {1'b0, pos_reg, 1'b1};
    assign kid_r   = kid_l + KID_W'(1);
    assign cnt_ext = KID_W'(cnt_reg);
    assign up_idx  = (pos_reg - IDX_W'(1)) >> 1;
    assign cnt_dec = cnt_reg - CNT_W'(1);

    assign new_entry.id       = req.requester_id;
    assign new_entry.arrival  = req.arrival_time;
    assign new_entry.deadline = req.deadline_time;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        orig_next     = orig_reg;
        m_next        = m_reg;
        best_next     = best_reg;
        took_next     = took_reg;
        removing_next = removing_reg;
        key_next      = key_reg;
        dropped_next  = dropped_reg;
        missed_next   = missed_reg;
        mode_next     = cfg_we ? cfg_wdata : mode_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = m_reg;
        rd_addr       = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dropped_next = 1'b0;
                    missed_next  = 1'b0;
                    if (req.req_type == REQ_PUSH)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            dropped_next = 1'b1;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            m_next        = new_entry;
                            pos_next      = cnt_reg[IDX_W-1:0];
                            cnt_next      = cnt_reg + CNT_W'(1);
                            removing_next = 1'b0;
                            state_next    = S_UP_RD;
                        end
                    end
                    else
                    begin
                        key_next   = req.requester_id;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                rd_addr = cnt_dec[IDX_W-1:0];
                if (!found)
                begin
                    missed_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_dec;
                    if (hit_idx == cnt_dec[IDX_W-1:0])
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        m_next        = rd_bus;
                        pos_next      = hit_idx;
                        orig_next     = hit_idx;
                        removing_next = 1'b1;
                        state_next    = S_UP_RD;
                    end
                end
            end

            S_UP_RD:
            begin
                rd_addr = up_idx;
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = removing_reg ? S_DN_START : S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (comes_first(rd_reg, m_reg, mode_reg))
                begin
                    state_next = removing_reg ? S_DN_START : S_DONE;
                end
                else
                begin
                    wr_data    = rd_reg;
                    pos_next   = up_idx;
                    state_next = S_UP_RD;
                end
            end

            S_DN_START:
            begin
                rd_addr    = orig_reg;
                m_next     = rd_bus;
                pos_next   = orig_reg;
                state_next = S_DN_L;
            end

            S_DN_L:
            begin
                rd_addr = kid_l[IDX_W-1:0];
                if (kid_l >= cnt_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_LC;
                end
            end

            S_DN_LC:
            begin
                rd_addr   = kid_r[IDX_W-1:0];
                took_next = comes_first(rd_reg, m_reg, mode_reg);
                best_next = took_next ? rd_reg : m_reg;
                if (kid_r < cnt_ext)
                begin
                    state_next = S_DN_RC;
                end
                else if (took_next)
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_reg;
                    pos_next   = kid_l[IDX_W-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DN_RC:
            begin
                wr_en = 1'b1;
                if (comes_first(rd_reg, best_reg, mode_reg))
                begin
                    wr_data    = rd_reg;
                    pos_next   = kid_r[IDX_W-1:0];
                    state_next = S_DN_L;
                end
                else if (took_reg)
                begin
                    wr_data    = best_reg;
                    pos_next   = kid_l[IDX_W-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                rsp_next.head_valid    = (cnt_reg != '0);
                rsp_next.head_id       = (cnt_reg != '0) ? cell_q[0].id : '0;
                rsp_next.waiting_count = COUNT_OUT_W'(cnt_reg);
                rsp_next.push_dropped  = dropped_reg;
                rsp_next.remove_missed = missed_reg;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_next = rd_bus;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            mode_reg     <= MODE_ARRIVAL;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
            pos_reg      <= '0;
            orig_reg     <= '0;
            m_reg        <= '0;
            rd_reg       <= '0;
            best_reg     <= '0;
            took_reg     <= 1'b0;
            removing_reg <= 1'b0;
            key_reg      <= '0;
            dropped_reg  <= 1'b0;
            missed_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            mode_reg     <= mode_next;
            done_reg     <= done_next;
            rsp_reg      <= rsp_next;
            pos_reg      <= pos_next;
            orig_reg     <= orig_next;
            m_reg        <= m_next;
            rd_reg       <= rd_next;
            best_reg     <= best_next;
            took_reg     <= took_next;
            removing_reg <= removing_next;
            key_reg      <= key_next;
            dropped_reg  <= dropped_next;
            missed_reg   <= missed_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one first match");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.push_dropped |-> rsp.waiting_count == COUNT_OUT_W'(CAPACITY))
        else $error("push dropped while store not full");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.push_dropped && rsp.remove_missed))
        else $error("drop and miss flagged together");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == REQ_PUSH && cnt_reg < CNT_W'(CAPACITY)
        |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("push did not grow the count");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.head_valid == (rsp.waiting_count != '0))
        else $error("head valid disagrees with count");

endmodule

/* verif/tb_request_priority_queue.sv */
// tb_request_priority_queue: self-checking bench for the request priority queue.
// Holds a heap predictor, a queued command driver, a result monitor and a stall watchdog.
// Depends on rpq_pkg and request_priority_queue.
module tb_request_priority_queue
    import rpq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 30;
    localparam int END_CYCLES    = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 70;
    localparam int PRINT_LIMIT   = 25;

    typedef enum logic [1:0] {ACT_ITEM, ACT_SETTLE, ACT_MODE} act_kind_t;

    typedef struct {
        act_kind_t kind;
        req_t      req;
        int        gap;
        logic      mode;
    } action_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic start     = 1'b0;
    logic busy;
    req_t req       = '0;
    logic done;
    rsp_t rsp;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    action_t pending[$];
    rsp_t    expected_rsp[$];

    entry_t pq_slot [CAPACITY];
    int     pq_count = 0;
    logic   pq_mode  = MODE_ARRIVAL;

    int total_items  = 0;
    int items_sent   = 0;
    int rsp_seen     = 0;
    int err_count    = 0;
    int gap_left     = 0;
    int settle_cnt   = 0;
    int stall_cycles = 0;
    int n_push       = 0;
    int n_drop       = 0;
    int n_remove     = 0;
    int n_miss       = 0;
    int n_modes      = 0;
    int peak_count   = 0;

    request_priority_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // --- heap predictor ---
    function automatic logic served_first(entry_t a, entry_t b);
        if (pq_mode == MODE_DEADLINE && a.deadline != b.deadline)
        begin
            return a.deadline < b.deadline;
        end
        if (a.arrival != b.arrival)
        begin
            return a.arrival < b.arrival;
        end
        return a.id <= b.id;
    endfunction

    function automatic void swap_slots(int a, int b);
        entry_t t;
        t          = pq_slot[a];
        pq_slot[a] = pq_slot[b];
        pq_slot[b] = t;
    endfunction

    function automatic void sift_up(int pos);
        while (pos > 0 && !served_first(pq_slot[(pos - 1) / 2], pq_slot[pos]))
        begin
            swap_slots((pos - 1) / 2, pos);
            pos = (pos - 1) / 2;
        end
    endfunction

    function automatic void sift_down(int pos);
        int   pick;
        int   kid;
        logic moving;
        moving = 1'b1;
        while (moving)
        begin
            pick = pos;
            kid  = 2 * pos + 1;
            if (kid < pq_count && served_first(pq_slot[kid], pq_slot[pick]))
                pick = kid;
            if (kid + 1 < pq_count && served_first(pq_slot[kid + 1], pq_slot[pick]))
                pick = kid + 1;
            if (pick == pos)
            begin
                moving = 1'b0;
            end
            else
            begin
                swap_slots(pos, pick);
                pos = pick;
            end
        end
    endfunction

    function automatic rsp_t queue_step(req_t r);
        rsp_t o;
        int   pos;
        o = '0;
        if (r.req_type == REQ_PUSH)
        begin
            if (pq_count >= CAPACITY)
            begin
                o.push_dropped = 1'b1;
            end
            else
            begin
                pos                   = pq_count;
                pq_slot[pos].id       = r.requester_id;
                pq_slot[pos].arrival  = r.arrival_time;
                pq_slot[pos].deadline = r.deadline_time;
                pq_count++;
                sift_up(pos);
            end
        end
        else
        begin
            pos = 0;
            while (pos < pq_count && pq_slot[pos].id != r.requester_id)
                pos++;
            if (pos == pq_count)
            begin
                o.remove_missed = 1'b1;
            end
            else
            begin
                pq_count--;
                if (pos != pq_count)
                begin
                    pq_slot[pos] = pq_slot[pq_count];
                    sift_up(pos);
                    sift_down(pos);
                end
            end
        end
        o.head_valid    = (pq_count != 0);
        o.head_id       = (pq_count != 0) ? pq_slot[0].id : '0;
        o.waiting_count = COUNT_OUT_W'(pq_count);
        return o;
    endfunction

    // --- stimulus building ---
    task automatic add_item(logic kind, logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
                            logic [TIME_W-1:0] dl, int gap);
        action_t a;
        a.kind              = ACT_ITEM;
        a.req.req_type      = kind;
        a.req.requester_id  = id;
        a.req.arrival_time  = arr;
        a.req.deadline_time = dl;
        a.gap               = gap;
        a.mode              = 1'b0;
        pending.push_back(a);
        total_items++;
    endtask

    task automatic add_settle();
        action_t a;
        a.kind = ACT_SETTLE;
        a.req  = '0;
        a.gap  = 0;
        a.mode = 1'b0;
        pending.push_back(a);
    endtask

    task automatic add_mode(logic m);
        action_t a;
        add_settle();
        a.kind = ACT_MODE;
        a.req  = '0;
        a.gap  = 0;
        a.mode = m;
        pending.push_back(a);
    endtask

    function automatic logic [TIME_W-1:0] pick_ts();
        unique case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return TIME_W'($urandom_range(0, 7));
            3:       return TIME_W'($urandom_range(0, 1000));
            default: return TIME_W'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7)
            return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t result %0d: %s got %0h want %0h", $time, rsp_seen, what, got, want);
    endtask

    // --- driver ---
    always @(posedge clk)
    begin : driver
        action_t act;
        rsp_t    pred;
        logic    next_start;
        logic    next_we;
        next_start = start;
        next_we    = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pred = queue_step(req);
                expected_rsp.push_back(pred);
                items_sent++;
                if (req.req_type == REQ_PUSH)
                    n_push++;
                else
                    n_remove++;
                if (pred.push_dropped)
                    n_drop++;
                if (pred.remove_missed)
                    n_miss++;
                if (pq_count > peak_count)
                    peak_count = pq_count;
                next_start = 1'b0;
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending.size() > 0)
                begin
                    act = pending[0];
                    unique case (act.kind)
                        ACT_ITEM:
                        begin
                            req        <= act.req;
                            next_start = 1'b1;
                            gap_left   = act.gap;
                            void'(pending.pop_front());
                        end
                        ACT_SETTLE:
                        begin
                            if (expected_rsp.size() != 0)
                            begin
                                settle_cnt = 0;
                            end
                            else if (settle_cnt < SETTLE_CYCLES)
                            begin
                                settle_cnt++;
                            end
                            else
                            begin
                                settle_cnt = 0;
                                void'(pending.pop_front());
                            end
                        end
                        default:
                        begin
                            next_we   = 1'b1;
                            cfg_wdata <= act.mode;
                            pq_mode   = act.mode;
                            n_modes++;
                            void'(pending.pop_front());
                        end
                    endcase
                end
            end
        end
        start  <= next_start;
        cfg_we <= next_we;
    end

    // --- monitor ---
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'(rsp), '0);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.head_valid !== want.head_valid)
                    report_mismatch("head_valid", 32'(rsp.head_valid),
                                    32'(want.head_valid));
                if (rsp.head_id !== want.head_id)
                    report_mismatch("head_id", 32'(rsp.head_id), 32'(want.head_id));
                if (rsp.waiting_count !== want.waiting_count)
                    report_mismatch("waiting_count", 32'(rsp.waiting_count),
                                    32'(want.waiting_count));
                if (rsp.push_dropped !== want.push_dropped)
                    report_mismatch("push_dropped", 32'(rsp.push_dropped),
                                    32'(want.push_dropped));
                if (rsp.remove_missed !== want.remove_missed)
                    report_mismatch("remove_missed", 32'(rsp.remove_missed),
                                    32'(want.remove_missed));
            end
            rsp_seen++;
        end
    end

    // --- watchdog ---
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t no progress for %0d cycles, %0d items sent, %0d results pending",
                     $time, STALL_LIMIT, items_sent, expected_rsp.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   p;
        int   k;
        int   push_pct;
        logic no_gaps;
        logic m;

        // directed: empty remove, field extremes, ties, duplicates, full store
        add_item(REQ_REMOVE, 8'd3, '0, '0, $urandom_range(0, 3));
        add_item(REQ_PUSH, 8'hFF, '1, '0, $urandom_range(0, 3));
        add_item(REQ_PUSH, 8'h00, '0, '1, $urandom_range(0, 3));
        add_item(REQ_PUSH, 8'd7, '0, 32'd5, $urandom_range(0, 3));
        add_item(REQ_PUSH, 8'd7, 32'd50, 32'd1, $urandom_range(0, 3));
        for (k = 0; k < 12; k++)
            add_item(REQ_PUSH, ID_W'(20 + k), TIME_W'(1000 - 60 * k), TIME_W'(40 * k + 3),
                     $urandom_range(0, 3));
        add_item(REQ_PUSH, 8'd99, 32'd1, 32'd1, $urandom_range(0, 3));
        // mode flip with a full store, then unwind
        add_mode(MODE_DEADLINE);
        add_item(REQ_REMOVE, 8'd7, '1, '1, $urandom_range(0, 3));
        add_item(REQ_REMOVE, 8'd7, '0, '0, $urandom_range(0, 3));
        add_item(REQ_REMOVE, 8'd7, '0, '0, $urandom_range(0, 3));
        add_item(REQ_REMOVE, 8'h00, '0, '0, $urandom_range(0, 3));
        add_item(REQ_REMOVE, 8'hFF, '0, '0, $urandom_range(0, 3));

        // random phases: fill-heavy, drain-heavy and balanced, mode rewritten each phase
        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                m = MODE_DEADLINE;
            else if (p == 1)
                m = MODE_ARRIVAL;
            else
                m = 1'($urandom_range(0, 1));
            add_mode(m);
            push_pct = (p % 3 == 0) ? 80 : ((p % 3 == 1) ? 35 : 55);
            no_gaps  = (p % 4 == 0);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 3)
                    add_settle();
                add_item(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_REMOVE,
                         pick_id(), pick_ts(), pick_ts(),
                         no_gaps ? 0 : $urandom_range(0, 3));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (items_sent < total_items || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        $display("covered %0d pushes (%0d dropped) and %0d removes (%0d missed)",
                 n_push, n_drop, n_remove, n_miss);
        $display("%0d order mode writes, peak occupancy %0d, %0d results checked",
                 n_modes, peak_count, rsp_seen);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/rpq_pkg.sv
design/rpq_cell.sv
design/request_priority_queue.sv
verif/tb_request_priority_queue.sv
